/* hdl/rlw_pkg.sv */
// ----------------------------------------------------------------------------
// rlw_pkg: shared types and constants for the radial lens warp
// Register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package rlw_pkg;

	localparam int COORD_W  = 24;
	localparam int REG_W    = 16;
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_QUAD   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CUBIC  = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_X  = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_Y  = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd5;
	localparam logic [IDX_W-1:0] REG_ZOOM   = 3'd6;

	localparam logic [REG_W-1:0] RST_WIDTH  = 16'd1920;
	localparam logic [REG_W-1:0] RST_HEIGHT = 16'd1080;
	localparam logic [REG_W-1:0] RST_ZOOM   = 16'd4096;

	// long divider: unsigned dividend / divisor, quotient with overflow flag
	localparam int DIV_NUM_W = 57;
	localparam int DIV_DEN_W = 21;
	localparam int DIV_Q_W   = 25;
	localparam int DIV_LAT   = DIV_Q_W + 1;

	// square root: floor(sqrt(x)), one result bit per stage
	localparam int SQ_IN_W  = 42;
	localparam int SQ_W     = SQ_IN_W / 2;
	localparam int SQ_REM_W = SQ_W + 2;

	localparam int TOTAL_STAGES = 84;

	typedef struct packed {
		logic signed [26:0] dx;
		logic signed [26:0] dy;
	} ofs_t;

	typedef struct packed {
		logic signed [26:0] dx;
		logic signed [26:0] dy;
		logic [27:0]        r2;
	} ofs_r2_t;

endpackage

/* hdl/rlw_div.sv */
// ----------------------------------------------------------------------------
// rlw_div: pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit DIV_Q_W bits.
// ----------------------------------------------------------------------------
module rlw_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rlw_pkg::DIV_NUM_W-1:0] num,
	input  logic [rlw_pkg::DIV_DEN_W-1:0] den,
	output logic [rlw_pkg::DIV_Q_W-1:0]   quo,
	output logic                          ovf
);

	localparam int NW = rlw_pkg::DIV_NUM_W;
	localparam int DW = rlw_pkg::DIV_DEN_W;
	localparam int QW = rlw_pkg::DIV_Q_W;

	logic [DW-1:0] rem_q [0:QW];
	logic [QW-1:0] low_q [0:QW];
	logic [QW-1:0] quo_q [0:QW];
	logic          ovf_q [0:QW];

	logic [DW:0]   sh_c   [1:QW];
	logic [DW:0]   diff_c [1:QW];

	always_comb begin
		for (int i = 1; i <= QW; i++) begin
			sh_c[i]   = {rem_q[i-1], low_q[i-1][QW-1]};
			diff_c[i] = sh_c[i] - {1'b0, den};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0] <= num[NW-1:QW] >= (NW-QW)'(den);
			rem_q[0] <= num[QW+DW-1:QW];
			low_q[0] <= num[QW-1:0];
			quo_q[0] <= '0;
			for (int i = 1; i <= QW; i++) begin
				ovf_q[i] <= ovf_q[i-1];
				low_q[i] <= {low_q[i-1][QW-2:0], 1'b0};
				if (sh_c[i] >= {1'b0, den}) begin
					rem_q[i] <= diff_c[i][DW-1:0];
					quo_q[i] <= {quo_q[i-1][QW-2:0], 1'b1};
				end else begin
					rem_q[i] <= sh_c[i][DW-1:0];
					quo_q[i] <= {quo_q[i-1][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule

/* hdl/rlw_sqrt.sv */
// ----------------------------------------------------------------------------
// rlw_sqrt: pipelined integer square root
// Digit-by-digit method, one root bit per stage, result floored.
// ----------------------------------------------------------------------------
module rlw_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rlw_pkg::SQ_IN_W-1:0]  x,
	output logic [rlw_pkg::SQ_W-1:0]     root
);

	localparam int XW = rlw_pkg::SQ_IN_W;
	localparam int RW = rlw_pkg::SQ_W;
	localparam int MW = rlw_pkg::SQ_REM_W;

	logic [MW-1:0] rem_q  [0:RW-1];
	logic [RW-1:0] root_q [0:RW-1];
	logic [XW-1:0] x_q    [0:RW-1];

	logic [MW-1:0] in_rem  [0:RW-1];
	logic [RW-1:0] in_root [0:RW-1];
	logic [XW-1:0] in_x    [0:RW-1];
	logic [MW+1:0] rem4_c  [0:RW-1];
	logic [MW+1:0] trial_c [0:RW-1];

	always_comb begin
		in_rem[0]  = '0;
		in_root[0] = '0;
		in_x[0]    = x;
		for (int j = 1; j < RW; j++) begin
			in_rem[j]  = rem_q[j-1];
			in_root[j] = root_q[j-1];
			in_x[j]    = x_q[j-1];
		end
		for (int j = 0; j < RW; j++) begin
			rem4_c[j]  = {in_rem[j], in_x[j][XW-1 -: 2]};
			trial_c[j] = {2'b00, in_root[j], 2'b01};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < RW; j++) begin
				x_q[j] <= {in_x[j][XW-3:0], 2'b00};
				if (rem4_c[j] >= trial_c[j]) begin
					rem_q[j]  <= MW'(rem4_c[j] - trial_c[j]);
					root_q[j] <= {in_root[j][RW-2:0], 1'b1};
				end else begin
					rem_q[j]  <= rem4_c[j][MW-1:0];
					root_q[j] <= {in_root[j][RW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[RW-1];

endmodule

/* hdl/radial_lens_distortion_warp_unit.sv */
// ----------------------------------------------------------------------------
// radial_lens_distortion_warp_unit: radial lens distortion coordinate warp
// Maps a destination pixel coordinate to its distorted source coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one destination coordinate per transaction; m_tdata
//   returns the source coordinate and m_tuser flags saturation.
//   cfg_* writes the seven setup registers; write only while idle.
//   One coordinate per cycle is accepted and delivered while the output
//   is not stalled. The pipeline depth comes from the two 26-stage dividers
//   (offset normalization and zoom) and the 21-stage square root.
//   Reset clears all valid bits and loads the register reset values.
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module radial_lens_distortion_warp_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // dest_x[23:0], dest_y[47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // src_x[23:0], src_y[47:24]
	output logic [0:0]  m_tuser,    // clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int NDL = rlw_pkg::DIV_LAT;
	localparam int NSQ = rlw_pkg::SQ_W;

	logic [15:0] quad_q, cubic_q, minx_q, miny_q, width_q, height_q, zoom_q;
	logic [rlw_pkg::TOTAL_STAGES-1:0] vld_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q   <= '0;
			cubic_q  <= '0;
			minx_q   <= '0;
			miny_q   <= '0;
			width_q  <= rlw_pkg::RST_WIDTH;
			height_q <= rlw_pkg::RST_HEIGHT;
			zoom_q   <= rlw_pkg::RST_ZOOM;
		end else if (cfg_valid) begin
			case (cfg_index)
				rlw_pkg::REG_QUAD:   quad_q   <= cfg_data;
				rlw_pkg::REG_CUBIC:  cubic_q  <= cfg_data;
				rlw_pkg::REG_MIN_X:  minx_q   <= cfg_data;
				rlw_pkg::REG_MIN_Y:  miny_q   <= cfg_data;
				rlw_pkg::REG_WIDTH:  width_q  <= cfg_data;
				rlw_pkg::REG_HEIGHT: height_q <= cfg_data;
				rlw_pkg::REG_ZOOM:   zoom_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[rlw_pkg::TOTAL_STAGES-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[rlw_pkg::TOTAL_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[rlw_pkg::TOTAL_STAGES-2:0], s_tvalid};
		end
	end

	// setup-derived values; the user must keep them static while items are in flight, the block does not enforce it
	logic [15:0]        len_c, zm_c;
	logic signed [17:0] bx_c, by_c;
	logic signed [25:0] cx2_c, cy2_c;

	always_comb begin
		len_c = (width_q > height_q) ? width_q : height_q;
		if (len_c == '0) len_c = 16'd1;
		zm_c = (zoom_q == '0) ? 16'd1 : zoom_q;
		bx_c  = $signed({minx_q[15], minx_q, 1'b0}) + $signed({2'b00, width_q});
		by_c  = $signed({miny_q[15], miny_q, 1'b0}) + $signed({2'b00, height_q});
		cx2_c = {bx_c, 8'd0};
		cy2_c = {by_c, 8'd0};
	end

	// s1: input register
	logic signed [23:0] px_s1, py_s1;
	// s2: doubled offsets and rounding dividends
	logic signed [26:0] dx_s2, dy_s2;
	logic [56:0]        ax_s2, ay_s2;
	logic signed [26:0] dxw_c, dyw_c;
	logic [26:0]        mx_c, my_c;

	always_comb begin
		dxw_c = $signed({{2{px_s1[23]}}, px_s1, 1'b0}) - $signed({cx2_c[25], cx2_c});
		dyw_c = $signed({{2{py_s1[23]}}, py_s1, 1'b0}) - $signed({cy2_c[25], cy2_c});
		mx_c  = dxw_c[26] ? (~dxw_c + 27'd1) : dxw_c;
		my_c  = dyw_c[26] ? (~dyw_c + 27'd1) : dyw_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= s_tdata[23:0];
			py_s1 <= s_tdata[47:24];
			dx_s2 <= dxw_c;
			dy_s2 <= dyw_c;
			ax_s2 <= {25'd0, mx_c[25:0], 6'd0} + {42'd0, len_c[15:1]};
			ay_s2 <= {25'd0, my_c[25:0], 6'd0} + {42'd0, len_c[15:1]};
		end
	end

	// s3..s28: normalization dividers
	logic [24:0] qnx, qny;
	logic        onx, ony;

	rlw_div u_div_nx (
		.clk(clk), .en(en), .num(ax_s2), .den({5'd0, len_c}), .quo(qnx), .ovf(onx)
	);
	rlw_div u_div_ny (
		.clk(clk), .en(en), .num(ay_s2), .den({5'd0, len_c}), .quo(qny), .ovf(ony)
	);

	rlw_pkg::ofs_t dla_q [0:NDL-1];
	always_ff @(posedge clk) begin
		if (en) begin
			dla_q[0] <= '{dx: dx_s2, dy: dy_s2};
			for (int i = 1; i < NDL; i++) dla_q[i] <= dla_q[i-1];
		end
	end

	// s29: clamp and square; s30: radius squared
	logic [20:0]        nmx_c, nmy_c;
	logic [41:0]        sqx_s29, sqy_s29, sqx_c, sqy_c;
	logic signed [26:0] dx_s29, dy_s29, dx_s30, dy_s30;
	logic [42:0]        rs_c;
	logic [27:0]        r2_s30;

	always_comb begin
		nmx_c = (onx || qnx > 25'h100000) ? 21'h100000 : qnx[20:0];
		nmy_c = (ony || qny > 25'h100000) ? 21'h100000 : qny[20:0];
		sqx_c = 42'(nmx_c) * 42'(nmx_c);
		sqy_c = 42'(nmy_c) * 42'(nmy_c);
		rs_c  = {1'b0, sqx_s29} + {1'b0, sqy_s29} + 43'd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s29 <= sqx_c;
			sqy_s29 <= sqy_c;
			dx_s29  <= dla_q[NDL-1].dx;
			dy_s29  <= dla_q[NDL-1].dy;
			r2_s30  <= rs_c[41:14];
			dx_s30  <= dx_s29;
			dy_s30  <= dy_s29;
		end
	end

	// s31..s51: square root
	logic [20:0] root_c;
	rlw_sqrt u_sqrt (.clk(clk), .en(en), .x({r2_s30, 14'd0}), .root(root_c));

	rlw_pkg::ofs_r2_t dlb_q [0:NSQ-1];
	always_ff @(posedge clk) begin
		if (en) begin
			dlb_q[0] <= '{dx: dx_s30, dy: dy_s30, r2: r2_s30};
			for (int i = 1; i < NSQ; i++) dlb_q[i] <= dlb_q[i-1];
		end
	end

	// s52..s55: gain polynomial
	logic signed [37:0] pk_s52, pkc;
	logic signed [24:0] t_s53;
	logic signed [53:0] pg_s54;
	logic signed [29:0] fg_s55;
	logic [27:0]        r2_s52, r2_s53;
	logic signed [26:0] dx_s52, dy_s52, dx_s53, dy_s53, dx_s54, dy_s54, dx_s55, dy_s55;
	logic [37:0]        pkm_c, pkr_c;
	logic [24:0]        rqs_c;
	logic signed [24:0] t_c;
	logic [53:0]        pgm_c, pgr_c;
	logic signed [41:0] g_c, fs_c;
	logic signed [27:0] f_c;

	always_comb begin
		pkc   = 38'($signed(cubic_q)) * 38'($signed({1'b0, root_c}));
		pkm_c = pk_s52[37] ? (~pk_s52 + 38'd1) : pk_s52;
		pkr_c = pkm_c + 38'd8192;
		rqs_c = {2'b00, pkr_c[36:14]};
		t_c   = $signed({{9{quad_q[15]}}, quad_q})
			+ (pk_s52[37] ? -$signed(rqs_c) : $signed(rqs_c));
		pgm_c = pg_s54[53] ? (~pg_s54 + 54'd1) : pg_s54;
		pgr_c = pgm_c + 54'd8192;
		g_c   = pg_s54[53] ? -$signed({2'b00, pgr_c[53:14]})
			: $signed({2'b00, pgr_c[53:14]});
		fs_c  = g_c + 42'sd16384;
		if (fs_c > 42'sd67108864)
			f_c = 28'sd67108864;
		else if (fs_c < -42'sd67108864)
			f_c = -28'sd67108864;
		else
			f_c = fs_c[27:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pk_s52 <= pkc;
			r2_s52 <= dlb_q[NSQ-1].r2;
			dx_s52 <= dlb_q[NSQ-1].dx;
			dy_s52 <= dlb_q[NSQ-1].dy;
			t_s53  <= t_c;
			r2_s53 <= r2_s52;
			dx_s53 <= dx_s52;
			dy_s53 <= dy_s52;
			pg_s54 <= 54'($signed({1'b0, r2_s53})) * 54'(t_s53);
			dx_s54 <= dx_s53;
			dy_s54 <= dy_s53;
			fg_s55 <= {f_c, 2'b00};
			dx_s55 <= dx_s54;
			dy_s55 <= dy_s54;
		end
	end

	// s56: offset and centre products; s57: rounding dividend
	logic signed [56:0] ox_s56, oy_s56;
	logic signed [42:0] cz_x_s56, cz_y_s56;
	logic signed [57:0] nx_c, ny_c;
	logic [57:0]        mnx_c, mny_c;
	logic [56:0]        mx_s57, my_s57;
	logic               sgx_s57, sgy_s57;

	always_comb begin
		nx_c  = $signed({{11{cz_x_s56[42]}}, cz_x_s56, 4'd0})
			+ $signed({ox_s56[56], ox_s56});
		ny_c  = $signed({{11{cz_y_s56[42]}}, cz_y_s56, 4'd0})
			+ $signed({oy_s56[56], oy_s56});
		mnx_c = nx_c[57] ? (~nx_c + 58'd1) : nx_c;
		mny_c = ny_c[57] ? (~ny_c + 58'd1) : ny_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s56   <= 57'(fg_s55) * 57'(dx_s55);
			oy_s56   <= 57'(fg_s55) * 57'(dy_s55);
			cz_x_s56 <= 43'(cx2_c) * 43'($signed({1'b0, zm_c}));
			cz_y_s56 <= 43'(cy2_c) * 43'($signed({1'b0, zm_c}));
			mx_s57   <= mnx_c[56:0] + {37'd0, zm_c, 4'd0};
			my_s57   <= mny_c[56:0] + {37'd0, zm_c, 4'd0};
			sgx_s57  <= nx_c[57];
			sgy_s57  <= ny_c[57];
		end
	end

	// s58..s83: zoom dividers
	logic [24:0] qfx, qfy;
	logic        ofx, ofy;

	rlw_div u_div_fx (
		.clk(clk), .en(en), .num(mx_s57), .den({zm_c, 5'd0}), .quo(qfx), .ovf(ofx)
	);
	rlw_div u_div_fy (
		.clk(clk), .en(en), .num(my_s57), .den({zm_c, 5'd0}), .quo(qfy), .ovf(ofy)
	);

	logic [1:0] dlc_q [0:NDL-1];
	always_ff @(posedge clk) begin
		if (en) begin
			dlc_q[0] <= {sgy_s57, sgx_s57};
			for (int i = 1; i < NDL; i++) dlc_q[i] <= dlc_q[i-1];
		end
	end

	// s84: saturation and output register
	logic [23:0] sx_c, sy_c;
	logic        cx_c, cy_c;
	logic [23:0] sx_s84, sy_s84;
	logic        clip_s84;

	always_comb begin
		if (dlc_q[NDL-1][0]) begin
			cx_c = ofx || qfx > 25'd8388608;
			sx_c = cx_c ? 24'h800000 : (~qfx[23:0] + 24'd1);
		end else begin
			cx_c = ofx || qfx > 25'd8388607;
			sx_c = cx_c ? 24'h7fffff : qfx[23:0];
		end
		if (dlc_q[NDL-1][1]) begin
			cy_c = ofy || qfy > 25'd8388608;
			sy_c = cy_c ? 24'h800000 : (~qfy[23:0] + 24'd1);
		end else begin
			cy_c = ofy || qfy > 25'd8388607;
			sy_c = cy_c ? 24'h7fffff : qfy[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s84   <= sx_c;
			sy_s84   <= sy_c;
			clip_s84 <= cx_c || cy_c;
		end
	end

	assign m_tdata = {sy_s84, sx_s84};
	assign m_tuser = clip_s84;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for radial_lens_distortion_warp_unit
// Streams destination coordinates under a series of lens, box and zoom
// settings, predicts every source coordinate in fixed point and compares
// each returned transaction in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rlw_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 100;

	typedef struct {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic                      clip;
	} warp_t;

	class warp_scoreboard;
		logic [REG_W-1:0] regs[7];
		warp_t            expected_q[$];
		int               mismatches;

		function new();
			regs[REG_QUAD]   = '0;
			regs[REG_CUBIC]  = '0;
			regs[REG_MIN_X]  = '0;
			regs[REG_MIN_Y]  = '0;
			regs[REG_WIDTH]  = RST_WIDTH;
			regs[REG_HEIGHT] = RST_HEIGHT;
			regs[REG_ZOOM]   = RST_ZOOM;
			mismatches = 0;
		endfunction

		static function longint rdiv(longint n, longint d);
			longint q;
			q = ((n < 0 ? -n : n) + d / 2) / d;
			return n < 0 ? -q : q;
		endfunction

		static function longint clampl(longint x, longint lo, longint hi);
			return x < lo ? lo : (x > hi ? hi : x);
		endfunction

		static function longint floor_sqrt(longint v);
			longint res, b;
			res = 0;
			b = longint'(1) << 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >>> 1) + b;
				end else begin
					res = res >>> 1;
				end
				b = b >>> 2;
			end
			return res;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
			if (idx < 7) regs[idx] = val;
		endfunction

		function void note_input(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
			longint px, py, k, k3, minx, miny, w, h, zm, len;
			longint cx2, cy2, dx2, dy2, nu, nv, r2, r, t, g, f, fg, sx, sy;
			warp_t  e;
			px   = longint'($signed(x));
			py   = longint'($signed(y));
			k    = longint'($signed(regs[REG_QUAD]));
			k3   = longint'($signed(regs[REG_CUBIC]));
			minx = longint'($signed(regs[REG_MIN_X]));
			miny = longint'($signed(regs[REG_MIN_Y]));
			w    = longint'(regs[REG_WIDTH]);
			h    = longint'(regs[REG_HEIGHT]);
			zm   = longint'(regs[REG_ZOOM]);
			len  = w > h ? w : h;
			if (len == 0) len = 1;
			if (zm == 0) zm = 1;
			cx2 = (2 * minx + w) * 256;
			cy2 = (2 * miny + h) * 256;
			dx2 = 2 * px - cx2;
			dy2 = 2 * py - cy2;
			nu = clampl(rdiv(dx2 * 16384, len * 256), -16384 * 64, 16384 * 64);
			nv = clampl(rdiv(dy2 * 16384, len * 256), -16384 * 64, 16384 * 64);
			r2 = (nu * nu + nv * nv + 8192) >>> 14;
			r  = floor_sqrt(r2 << 14);
			t  = k + rdiv(k3 * r, 16384);
			g  = rdiv(r2 * t, 16384);
			f  = clampl(16384 + g, -16384 * 4096, 16384 * 4096);
			fg = f * 4;
			sx = rdiv(cx2 * 16 * zm + fg * dx2, zm * 32);
			sy = rdiv(cy2 * 16 * zm + fg * dy2, zm * 32);
			e.clip = (sx > 8388607 || sx < -8388608 || sy > 8388607 || sy < -8388608);
			e.sx = COORD_W'(clampl(sx, -8388608, 8388607));
			e.sy = COORD_W'(clampl(sy, -8388608, 8388607));
			expected_q.push_back(e);
		endfunction

		function void check(logic [47:0] data, logic clip);
			warp_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", data);
				return;
			end
			e = expected_q.pop_front();
			if (data[23:0] !== e.sx || data[47:24] !== e.sy || clip !== e.clip) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp x=%h y=%h clip=%b got x=%h y=%h clip=%b",
						e.sx, e.sy, e.clip, data[23:0], data[47:24], clip);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	warp_scoreboard coord_sb = new();
	int  send_idle = 10;
	int  recv_idle = 55;
	int  hold_cycles = 0;
	int  quiet = 0;
	int  sent = 0;

	radial_lens_distortion_warp_unit DUT (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) coord_sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) coord_sb.note_input(s_tdata[23:0], s_tdata[47:24]);
			if (m_tvalid && m_tready) coord_sb.check(m_tdata, m_tuser[0]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("radial_lens_distortion_warp_unit regression: fail");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready = 0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_coord(logic [23:0] x, logic [23:0] y);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata  = {y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (sent == 700) send_idle = 55;
		if (sent == 700) recv_idle = 10;
		if (sent == 1400) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (coord_sb.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_all(int k, int k3, int mx, int my, int w, int h, int zm);
		drain();
		write_cfg(REG_QUAD, 16'(k));
		write_cfg(REG_CUBIC, 16'(k3));
		write_cfg(REG_MIN_X, 16'(mx));
		write_cfg(REG_MIN_Y, 16'(my));
		write_cfg(REG_WIDTH, 16'(w));
		write_cfg(REG_HEIGHT, 16'(h));
		write_cfg(REG_ZOOM, 16'(zm));
	endtask

	task automatic random_coords(int n);
		longint mx, my, w, h, x, y;
		for (int i = 0; i < n; i++) begin
			mx = longint'($signed(coord_sb.regs[REG_MIN_X]));
			my = longint'($signed(coord_sb.regs[REG_MIN_Y]));
			w  = longint'(coord_sb.regs[REG_WIDTH]);
			h  = longint'(coord_sb.regs[REG_HEIGHT]);
			if ($urandom_range(0, 9) < 7) begin
				x = mx * 256 + longint'($urandom_range(0, 32'(w * 320))) - w * 32;
				y = my * 256 + longint'($urandom_range(0, 32'(h * 320))) - h * 32;
			end else begin
				x = longint'($urandom);
				y = longint'($urandom);
			end
			send_coord(24'(x), 24'(y));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes, centre, box corners under reset settings, then under other settings
		send_coord(24'h000000, 24'h000000);
		send_coord(24'h7FFFFF, 24'h7FFFFF);
		send_coord(24'h800000, 24'h800000);
		send_coord(24'h7FFFFF, 24'h800000);
		send_coord(24'h800000, 24'h7FFFFF);
		send_coord(24'(960 * 256), 24'(540 * 256));
		send_coord(24'(1920 * 256), 24'(1080 * 256));
		send_coord(24'hFFFFFF, 24'hFFFFFF);
		set_all(16384, 16384, 0, 0, 1920, 1080, 4096);
		send_coord(24'h000000, 24'h000000);
		send_coord(24'h7FFFFF, 24'h000000);
		send_coord(24'(1920 * 256), 24'(540 * 256));
		set_all(-16384, -16384, -32768, 32767, 1, 1, 410);
		send_coord(24'h800000, 24'h7FFFFF);
		send_coord(24'h000000, 24'h000000);
		send_coord(24'(-32768 * 256), 24'(32767 * 256));
		set_all(0, 0, 0, 0, 0, 0, 0);
		send_coord(24'h000100, 24'h000200);
		send_coord(24'h7FFFFF, 24'h800000);
		set_all(16'h8000, 16'h7FFF, 100, -100, 32768, 16, 40960);
		send_coord(24'h000000, 24'h000000);
		send_coord(24'h7FFFFF, 24'h7FFFFF);

		set_all(0, 0, 0, 0, 1920, 1080, 4096);
		random_coords(200);
		set_all(3000, -1200, 0, 0, 640, 480, 4096);
		random_coords(150);
		// long receiver stall while the sender keeps offering
		hold_cycles = 400;
		random_coords(150);
		set_all(16384, 16384, -500, -300, 1000, 1000, 410);
		random_coords(200);
		set_all(-16384, -16384, 32767, -32768, 32768, 1, 40960);
		random_coords(200);
		set_all(0, 0, 0, 0, 0, 0, 0);
		random_coords(150);
		for (int p = 0; p < 6; p++) begin
			set_all($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(1, 32768), $urandom_range(1, 32768),
				$urandom_range(410, 40960));
			if (p == 3) hold_cycles = 300;
			random_coords(160);
		end

		drain();
		if (coord_sb.mismatches == 0 && coord_sb.expected_q.size() == 0)
			$display("radial_lens_distortion_warp_unit regression: pass");
		else
			$display("radial_lens_distortion_warp_unit regression: fail");
		$finish;
	end

endmodule
